>>> hdl/awbg_pkg.sv
// shared types and constants for the otp white-balance gain calculator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package awbg_pkg;
    localparam int RATIO_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int SHIFT_W  = 10;
    localparam int Q1_W     = RATIO_W + SHIFT_W;
    localparam int Q2_W     = Q1_W + RATIO_W;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN      = 16'h0400;
    localparam logic [GAIN_W-1:0]  GAIN_MAX        = 16'hFFFF;
    localparam logic [RATIO_W-1:0] RG_GOLDEN_RESET = 16'h026C;
    localparam logic [RATIO_W-1:0] BG_GOLDEN_RESET = 16'h02ED;

    // register indexes
    localparam logic REG_RG_GOLDEN = 1'b0;
    localparam logic REG_BG_GOLDEN = 1'b1;

    // which gain is pinned at unity
    localparam logic [1:0] MODE_GREEN_PIN = 2'd0;
    localparam logic [1:0] MODE_RED_PIN   = 2'd1;
    localparam logic [1:0] MODE_BLUE_PIN  = 2'd2;

    typedef struct packed {
        logic [RATIO_W-1:0] rg;
        logic [RATIO_W-1:0] bg;
        logic               err;
        logic               bg_lt;
        logic               rg_lt;
    } awbg_item_t;
endpackage
`default_nettype wire

>>> hdl/awbg_front.sv
// front stage: accepts items, flags errors and compares against golden ratios
// depends on awbg_pkg
`timescale 1ns / 1ps
`default_nettype none
module awbg_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [awbg_pkg::RATIO_W-1:0] rg_meas,
    input  wire logic [awbg_pkg::RATIO_W-1:0] bg_meas,
    input  wire logic                         awb_valid,
    input  wire logic [awbg_pkg::RATIO_W-1:0] rg_golden,
    input  wire logic [awbg_pkg::RATIO_W-1:0] bg_golden,
    output logic                              push,
    output awbg_pkg::awbg_item_t              push_item,
    input  wire logic                         q_full
);
    logic                 vld_reg;
    awbg_pkg::awbg_item_t item_reg;

    assign push      = vld_reg && !q_full;
    assign in_ready  = !vld_reg || !q_full;
    assign push_item = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_reg.rg    <= rg_meas;
            item_reg.bg    <= bg_meas;
            item_reg.err   <= !awb_valid || (rg_meas == '0) || (bg_meas == '0);
            item_reg.bg_lt <= bg_meas < bg_golden;
            item_reg.rg_lt <= rg_meas < rg_golden;
        end
    end
endmodule
`default_nettype wire

>>> hdl/awbg_fifo.sv
// short queue of classified items between front and back
// depends on awbg_pkg
`timescale 1ns / 1ps
`default_nettype none
module awbg_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire awbg_pkg::awbg_item_t push_item,
    output logic                      full,
    input  wire logic                 pop,
    output awbg_pkg::awbg_item_t      pop_item,
    output logic                      empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    awbg_pkg::awbg_item_t mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;

    assign full     = cnt_reg == CW'(DEPTH);
    assign empty    = cnt_reg == '0;
    assign pop_item = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        if (push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end
endmodule
`default_nettype wire

>>> hdl/awbg_div.sv
// pipelined restoring divider, one quotient bit per stage, with a side tag
// depends on nothing; a zero divisor gives an all-ones quotient
`timescale 1ns / 1ps
`default_nettype none
module awbg_div #(
    parameter int NW = 26,
    parameter int DW = 16,
    parameter int TW = 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [TW-1:0] tag,
    output logic               out_valid,
    output logic [NW-1:0]      quo,
    output logic [TW-1:0]      out_tag
);
    logic          vld_reg [NW];
    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [NW-1:0] quo_reg [NW];
    logic [DW-1:0] den_reg [NW];
    logic [TW-1:0] tag_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          vld_prev;
        logic [DW-1:0] rem_prev, den_prev;
        logic [NW-1:0] num_prev, quo_prev;
        logic [TW-1:0] tag_prev;
        logic [DW:0]   trial, diff;
        logic          ge;
        logic [DW-1:0] rem_next;

        if (k == 0) begin : g_first
            assign vld_prev = in_valid;
            assign rem_prev = '0;
            assign num_prev = num;
            assign quo_prev = '0;
            assign den_prev = den;
            assign tag_prev = tag;
        end else begin : g_rest
            assign vld_prev = vld_reg[k-1];
            assign rem_prev = rem_reg[k-1];
            assign num_prev = num_reg[k-1];
            assign quo_prev = quo_reg[k-1];
            assign den_prev = den_reg[k-1];
            assign tag_prev = tag_reg[k-1];
        end

        assign trial    = {rem_prev, num_prev[NW-1]};
        assign diff     = trial - {1'b0, den_prev};
        assign ge       = trial >= {1'b0, den_prev};
        assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_prev;
            end
            if (en) begin
                rem_reg[k] <= rem_next;
                num_reg[k] <= num_prev << 1;
                quo_reg[k] <= {quo_prev[NW-2:0], ge};
                den_reg[k] <= den_prev;
                tag_reg[k] <= tag_prev;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign quo       = quo_reg[NW-1];
    assign out_tag   = tag_reg[NW-1];
endmodule
`default_nettype wire

>>> hdl/awbg_back.sv
// back part: green-gain dividers, pin select, scaling multiply, second dividers,
// saturation and output register; depends on awbg_pkg and awbg_div
`timescale 1ns / 1ps
`default_nettype none
module awbg_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_empty,
    input  wire awbg_pkg::awbg_item_t         q_item,
    output logic                              pop,
    input  wire logic [awbg_pkg::RATIO_W-1:0] rg_golden,
    input  wire logic [awbg_pkg::RATIO_W-1:0] bg_golden,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [awbg_pkg::GAIN_W-1:0]       red_gain,
    output logic [awbg_pkg::GAIN_W-1:0]       green_gain,
    output logic [awbg_pkg::GAIN_W-1:0]       blue_gain,
    output logic                              red_write,
    output logic                              green_write,
    output logic                              blue_write,
    output logic                              error
);
    localparam int RW = awbg_pkg::RATIO_W;
    localparam int GW = awbg_pkg::GAIN_W;
    localparam int Q1 = awbg_pkg::Q1_W;
    localparam int Q2 = awbg_pkg::Q2_W;
    localparam int T1 = 2 * RW + 2;
    localparam int T2 = 2 * RW + GW + 2;

    logic adv;
    assign adv = !out_valid || out_ready;
    assign pop = adv && !q_empty;

    // green gain candidates from blue and from red
    logic          v1b, v1r, e1;
    logic [Q1-1:0] qb1, qr1;
    logic [T1-1:0] t1;

    awbg_div #(.NW(Q1), .DW(RW), .TW(T1)) u_div_gb (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(!q_empty),
        .num({q_item.bg, {awbg_pkg::SHIFT_W{1'b0}}}), .den(bg_golden),
        .tag({q_item.rg, q_item.bg, q_item.bg_lt, q_item.rg_lt}),
        .out_valid(v1b), .quo(qb1), .out_tag(t1)
    );
    awbg_div #(.NW(Q1), .DW(RW), .TW(1)) u_div_gr (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(!q_empty),
        .num({q_item.rg, {awbg_pkg::SHIFT_W{1'b0}}}), .den(rg_golden),
        .tag(q_item.err), .out_valid(v1r), .quo(qr1), .out_tag(e1)
    );

    logic [Q1-1:0] from_b, from_r, m_next;
    logic [1:0]    mode_next;
    logic          bg_lt1, rg_lt1;

    assign bg_lt1 = t1[1];
    assign rg_lt1 = t1[0];
    assign from_b = (bg_golden == '0) ? Q1'(awbg_pkg::GAIN_MAX) : qb1;
    assign from_r = (rg_golden == '0) ? Q1'(awbg_pkg::GAIN_MAX) : qr1;

    always_comb begin
        if (bg_lt1 && rg_lt1) begin
            mode_next = awbg_pkg::MODE_GREEN_PIN;
        end else if (bg_lt1) begin
            mode_next = awbg_pkg::MODE_RED_PIN;
        end else if (rg_lt1) begin
            mode_next = awbg_pkg::MODE_BLUE_PIN;
        end else if (from_b > from_r) begin
            mode_next = awbg_pkg::MODE_BLUE_PIN;
        end else begin
            mode_next = awbg_pkg::MODE_RED_PIN;
        end
        case (mode_next)
            awbg_pkg::MODE_RED_PIN:  m_next = from_r;
            awbg_pkg::MODE_BLUE_PIN: m_next = from_b;
            default:                 m_next = Q1'(awbg_pkg::UNITY_GAIN);
        endcase
    end

    // select stage
    logic          sel_vld_reg, sel_err_reg;
    logic [Q1-1:0] sel_m_reg;
    logic [1:0]    sel_mode_reg;
    logic [RW-1:0] sel_rg_reg, sel_bg_reg;

    // multiply stage
    logic          mul_vld_reg, mul_err_reg;
    logic [Q2-1:0] mul_nb_reg, mul_nr_reg;
    logic [1:0]    mul_mode_reg;
    logic [RW-1:0] mul_rg_reg, mul_bg_reg;
    logic [GW-1:0] mul_g_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_vld_reg <= 1'b0;
            mul_vld_reg <= 1'b0;
        end else if (adv) begin
            sel_vld_reg <= v1b && v1r;
            mul_vld_reg <= sel_vld_reg;
        end
        if (adv) begin
            sel_err_reg  <= e1;
            sel_m_reg    <= m_next;
            sel_mode_reg <= mode_next;
            sel_rg_reg   <= t1[T1-1 -: RW];
            sel_bg_reg   <= t1[RW+1 -: RW];
            mul_err_reg  <= sel_err_reg;
            mul_nb_reg   <= sel_m_reg * bg_golden;
            mul_nr_reg   <= sel_m_reg * rg_golden;
            mul_mode_reg <= sel_mode_reg;
            mul_rg_reg   <= sel_rg_reg;
            mul_bg_reg   <= sel_bg_reg;
            mul_g_reg    <= (|sel_m_reg[Q1-1:GW]) ? awbg_pkg::GAIN_MAX : sel_m_reg[GW-1:0];
        end
    end

    // scaled gains divided by the module ratios
    logic          v2b, v2r, e2;
    logic [Q2-1:0] qb2, qr2;
    logic [T2-1:0] t2;

    awbg_div #(.NW(Q2), .DW(RW), .TW(T2)) u_div_b (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(mul_vld_reg),
        .num(mul_nb_reg), .den(mul_bg_reg),
        .tag({mul_rg_reg, mul_bg_reg, mul_g_reg, mul_mode_reg}),
        .out_valid(v2b), .quo(qb2), .out_tag(t2)
    );
    awbg_div #(.NW(Q2), .DW(RW), .TW(1)) u_div_r (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .in_valid(mul_vld_reg),
        .num(mul_nr_reg), .den(mul_rg_reg), .tag(mul_err_reg),
        .out_valid(v2r), .quo(qr2), .out_tag(e2)
    );

    logic [1:0]    mode2;
    logic [GW-1:0] g2, r_sat, b_sat, r_fin, b_fin;
    logic          nz2;

    assign mode2 = t2[1:0];
    assign g2    = t2[GW+1:2];
    // ratios ride along only to keep the tag honest about a zero divisor
    assign nz2   = (t2[T2-1 -: RW] != '0) && (t2[T2-RW-1 -: RW] != '0);
    assign r_sat = (|qr2[Q2-1:GW]) ? awbg_pkg::GAIN_MAX : qr2[GW-1:0];
    assign b_sat = (|qb2[Q2-1:GW]) ? awbg_pkg::GAIN_MAX : qb2[GW-1:0];
    assign r_fin = (mode2 == awbg_pkg::MODE_RED_PIN)  ? awbg_pkg::UNITY_GAIN : r_sat;
    assign b_fin = (mode2 == awbg_pkg::MODE_BLUE_PIN) ? awbg_pkg::UNITY_GAIN : b_sat;

    logic ok;
    assign ok = !e2 && nz2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (adv) begin
            out_valid <= v2b && v2r;
        end
        if (adv) begin
            red_gain    <= ok ? r_fin : '0;
            green_gain  <= ok ? g2 : '0;
            blue_gain   <= ok ? b_fin : '0;
            red_write   <= ok && (r_fin > awbg_pkg::UNITY_GAIN);
            green_write <= ok && (g2 > awbg_pkg::UNITY_GAIN);
            blue_write  <= ok && (b_fin > awbg_pkg::UNITY_GAIN);
            error       <= !ok;
        end
    end
endmodule
`default_nettype wire

>>> hdl/awb_otp_gain_calc.sv
// top level: golden-ratio registers on an apb port, front, queue and back
// depends on awbg_pkg, awbg_front, awbg_fifo, awbg_back
//
//   channel   ports                      contents
//   s_        tvalid tready tdata tuser  module ratios in, valid flag in tuser
//   m_        tvalid tready tdata        gains, write enables, error
//   cfg       psel penable pwrite paddr  rg_golden at 0x0, bg_golden at 0x4
//
// one item per cycle sustained while m_tready holds; an accepted item passes, with an empty queue,
// through the front register, the queue, 26 divider stages, the select and multiply registers,
// 42 divider stages and the output register, the two dividers giving one quotient bit per stage
// synchronous active-low reset clears all valid flags and loads the golden ratios
// a stalled result freezes the back pipeline; the queue keeps the front taking items until it fills
`timescale 1ns / 1ps
`default_nettype none
module awb_otp_gain_calc #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // r/g ratio [15:0], b/g ratio [31:16]
    input  wire logic        s_tuser,   // awb_valid
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // red_gain, green_gain, blue_gain, red_write,
                                        // green_write, blue_write, error, zero pad
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int RW = awbg_pkg::RATIO_W;
    localparam int GW = awbg_pkg::GAIN_W;

    logic [RW-1:0] rg_golden_reg, bg_golden_reg;

    assign pready = 1'b1;
    assign prdata = {16'h0, (paddr[2] == awbg_pkg::REG_BG_GOLDEN) ? bg_golden_reg
                                                                  : rg_golden_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rg_golden_reg <= awbg_pkg::RG_GOLDEN_RESET;
            bg_golden_reg <= awbg_pkg::BG_GOLDEN_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == awbg_pkg::REG_RG_GOLDEN) begin
                rg_golden_reg <= pwdata[RW-1:0];
            end else begin
                bg_golden_reg <= pwdata[RW-1:0];
            end
        end
    end

    logic                 push, pop, q_full, q_empty;
    awbg_pkg::awbg_item_t push_item, pop_item;

    awbg_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .rg_meas(s_tdata[15:0]), .bg_meas(s_tdata[31:16]), .awb_valid(s_tuser),
        .rg_golden(rg_golden_reg), .bg_golden(bg_golden_reg),
        .push(push), .push_item(push_item), .q_full(q_full)
    );

    awbg_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_item(push_item), .full(q_full),
        .pop(pop), .pop_item(pop_item), .empty(q_empty)
    );

    logic [GW-1:0] red_gain, green_gain, blue_gain;
    logic          red_write, green_write, blue_write, error;

    awbg_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_empty(q_empty), .q_item(pop_item), .pop(pop),
        .rg_golden(rg_golden_reg), .bg_golden(bg_golden_reg),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .red_gain(red_gain), .green_gain(green_gain), .blue_gain(blue_gain),
        .red_write(red_write), .green_write(green_write), .blue_write(blue_write),
        .error(error)
    );

    assign m_tdata = {4'h0, error, blue_write, green_write, red_write,
                      blue_gain, green_gain, red_gain};

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full) else $error("queue overflow");
    a_error_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && error |-> red_gain == '0 && green_gain == '0 && blue_gain == '0)
        else $error("error result carries gains");
    a_one_pinned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !error |-> red_gain == awbg_pkg::UNITY_GAIN ||
            green_gain == awbg_pkg::UNITY_GAIN || blue_gain == awbg_pkg::UNITY_GAIN)
        else $error("no gain pinned at unity");
`endif
endmodule
`default_nettype wire
